/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry.
    localparam int TCW_COLUMNS = 80;
    localparam int TCW_ROWS    = 25;

    // Character codes and cell constants.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // One input item.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } t_result;

    // A blank cell: a space under the given attribute.
    function automatic logic [15:0] blank_cell(input logic [7:0] attr);
        return {attr, CH_SPACE};
    endfunction

endpackage

/* rtl/tcw_item_if.sv */
// ----------------------------------------------------------------------------
// Text console item channel
// Valid/ready channel that carries one console item per transfer.
// ----------------------------------------------------------------------------
interface tcw_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;

    modport source (output valid, output op, output ch, output row, output col, input ready);
    modport sink   (input valid, input op, input ch, input row, input col, output ready);
endinterface

/* rtl/tcw_result_if.sv */
// ----------------------------------------------------------------------------
// Text console result channel
// Valid/ready channel that carries one console result per transfer.
// ----------------------------------------------------------------------------
interface tcw_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;

    modport source (output valid, output cell_data, output cursor_col, output cursor_row,
                    output scrolled, input ready);
    modport sink   (input valid, input cell_data, input cursor_col, input cursor_row,
                    input scrolled, output ready);
endinterface

/* rtl/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// Screen cell memory
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = TCW_ROWS * TCW_COLUMNS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// Console sequencer
// Holds the cursor and runs every item against the screen memory: cell
// writes, cell reads, the scroll copy and the fill sweeps.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS,
    localparam int DEPTH  = ROWS * COLUMNS,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_attr,
    input  logic          i_item_valid,
    input  t_item         i_item,
    output logic          o_item_ready,
    input  logic          i_slot_free,
    output logic          o_push,
    output t_result       o_res,
    output logic          o_wr_en,
    output logic [AW-1:0] o_waddr,
    output logic [15:0]   o_wdata,
    output logic          o_rd_en,
    output logic [AW-1:0] o_raddr,
    input  logic [15:0]   i_rdata
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam logic [AW-1:0] LAST_ADDR     = AW'(DEPTH - 1);
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST      = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST      = RW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_COPY,
        S_FILL,
        S_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    t_item         r_item, n_item;
    t_result       r_res, n_res;
    logic          r_wvalid, n_wvalid;
    logic [AW-1:0] r_wdst, n_wdst;

    logic [AW-1:0] cur_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;
    logic          is_nl, is_cr, printable, inc_row, do_scroll;
    logic [CW-1:0] put_col;
    logic [RW-1:0] put_row;
    t_result       put_res;
    t_result       idle_res;

    // Addresses of the cursor cell and of the requested cell.
    assign cur_addr    = AW'(AW'(r_row) * COLS_A) + AW'(r_col);
    assign rd_addr     = AW'(AW'(r_item.row) * COLS_A) + AW'(r_item.col);
    assign rd_in_range = (r_item.row < ROWS) && (r_item.col < COLUMNS);

    // Cursor movement of a put.
    assign is_nl     = (r_item.ch == CH_NEWLINE);
    assign is_cr     = (r_item.ch == CH_RETURN);
    assign printable = !is_nl && !is_cr;
    assign inc_row   = is_nl || (printable && (r_col == COL_LAST));
    assign do_scroll = inc_row && (r_row == ROW_LAST);
    assign put_col   = (!printable || (r_col == COL_LAST)) ? '0 : r_col + CW'(1);
    assign put_row   = (inc_row && !do_scroll) ? r_row + RW'(1) : r_row;

    always_comb begin
        put_res.cell_data  = '0;
        put_res.cursor_col = 7'(put_col);
        put_res.cursor_row = 5'(put_row);
        put_res.scrolled   = do_scroll;
        idle_res.cell_data  = '0;
        idle_res.cursor_col = 7'(r_col);
        idle_res.cursor_row = 5'(r_row);
        idle_res.scrolled   = 1'b0;
    end

    // Sequencer next state and memory requests.
    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_col        = r_col;
        n_row        = r_row;
        n_item       = r_item;
        n_res        = r_res;
        n_wvalid     = r_wvalid;
        n_wdst       = r_wdst;
        o_item_ready = 1'b0;
        o_push       = 1'b0;
        o_res        = r_res;
        o_wr_en      = 1'b0;
        o_waddr      = r_ptr;
        o_wdata      = blank_cell(i_attr);
        o_rd_en      = 1'b0;
        o_raddr      = r_ptr + COLS_A;

        case (r_state)
            // Clearing pass after reset, always under the reset attribute.
            S_INIT: begin
                o_wr_en = 1'b1;
                o_wdata = blank_cell(RESET_ATTR);
                if (r_ptr == LAST_ADDR) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end

            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_item.op)
                    OP_PUT: begin
                        if (do_scroll || i_slot_free) begin
                            o_wr_en = printable;
                            o_waddr = cur_addr;
                            o_wdata = {i_attr, r_item.ch};
                            n_col   = put_col;
                            n_row   = put_row;
                            if (do_scroll) begin
                                n_res    = put_res;
                                n_ptr    = '0;
                                n_wvalid = 1'b0;
                                n_state  = S_COPY;
                            end else begin
                                o_push  = 1'b1;
                                o_res   = put_res;
                                n_state = S_IDLE;
                            end
                        end
                    end
                    OP_READ: begin
                        if (rd_in_range) begin
                            o_rd_en = 1'b1;
                            o_raddr = rd_addr;
                            n_state = S_RDWAIT;
                        end else if (i_slot_free) begin
                            o_push  = 1'b1;
                            o_res   = idle_res;
                            n_state = S_IDLE;
                        end
                    end
                    OP_CLEAR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_ptr   = '0;
                        n_res   = '0;
                        n_state = S_FILL;
                    end
                    default: begin
                        if (i_slot_free) begin
                            o_push  = 1'b1;
                            o_res   = idle_res;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end

            // Read data is held in the memory output until the result leaves.
            S_RDWAIT: begin
                o_res           = idle_res;
                o_res.cell_data = i_rdata;
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // Scroll copy: read one row ahead, write back into the row above from the registered read data.
            S_COPY: begin
                o_wr_en = r_wvalid;
                o_waddr = r_wdst;
                o_wdata = i_rdata;
                if (r_ptr != LAST_ROW_BASE) begin
                    o_rd_en  = 1'b1;
                    n_wvalid = 1'b1;
                    n_wdst   = r_ptr;
                    n_ptr    = r_ptr + AW'(1);
                end else begin
                    n_wvalid = 1'b0;
                    n_state  = S_FILL;
                end
            end

            // Blank sweep up to the last cell: the bottom row or the whole screen.
            S_FILL: begin
                o_wr_en = 1'b1;
                if (r_ptr == LAST_ADDR) begin
                    n_ptr   = '0;
                    n_state = S_FIN;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end

            S_FIN: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ptr    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_wvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_col    <= n_col;
            r_row    <= n_row;
            r_wvalid <= n_wvalid;
        end
        r_item <= n_item;
        r_res  <= n_res;
        r_wdst <= n_wdst;
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_LAST) && (r_row <= ROW_LAST))
        else $error("cursor left the screen");

    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (o_waddr <= LAST_ADDR))
        else $error("write address beyond the screen");

    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_slot_free)
        else $error("result pushed into a full output register");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.scrolled) |-> (r_row == ROW_LAST))
        else $error("scroll finished off the last row");
`endif

endmodule

/* rtl/text_console_writer.sv */
// Sequence: an item is taken only while the sequencer is idle, so a new item waits
// until the last one is through. A put or read pushes its result once the output
// register is free; a scroll copies the rows up one cell per cycle through the
// single write port of the screen memory, then blanks the bottom row; a clear
// blanks every cell. Reset: synchronous, active low; afterwards a clearing pass
// writes all ROWS*COLUMNS cells and no item is taken until it ends.
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console with cursor, newline, carriage return and line scroll,
// built around one screen cell memory and a sequencer.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    tcw_item_if.sink     i_item,
    tcw_result_if.source o_result
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    r_attr;
    logic          r_out_valid;
    t_result       r_out;
    logic          slot_free;
    t_item         item;
    logic          push;
    t_result       res;
    logic          wr_en, rd_en;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;

    // Attribute register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // Input payload gathered into one item.
    always_comb begin
        item.op  = i_item.op;
        item.ch  = i_item.ch;
        item.row = i_item.row;
        item.col = i_item.col;
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (r_attr),
        .i_item_valid (i_item.valid),
        .i_item       (item),
        .o_item_ready (i_item.ready),
        .i_slot_free  (slot_free),
        .o_push       (push),
        .o_res        (res),
        .o_wr_en      (wr_en),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_rd_en      (rd_en),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    tcw_screen_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_rd_en (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register: frees in the cycle its transfer completes.
    assign slot_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (push) begin
            r_out <= res;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.cell_data  = r_out.cell_data;
    assign o_result.cursor_col = r_out.cursor_col;
    assign o_result.cursor_row = r_out.cursor_row;
    assign o_result.scrolled   = r_out.scrolled;

endmodule
